FILE: hdl/olar_pkg.sv
// Shared types and constants for the ordered list block.
package olar_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operation codes carried in the low bits of the input tdata.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ELEMENT   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SEARCH,
    S_SHIFT,
    S_DUMP
  } state_e;

  // Source of the value field of a result.
  typedef enum logic [1:0] {
    VAL_ITEM,
    VAL_RAM,
    VAL_ZERO
  } val_sel_e;

  // Source of a list write: tail append or gap closing.
  typedef enum logic {
    WR_TAIL,
    WR_SHIFT
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     idx_inc;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    status_e  status;
    val_sel_e val_sel;
    logic     last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_lt_cnt;
    logic idx_last;
    logic match;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/olar_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module olar_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/olar_ctrl.sv
// Sequencer for append, remove and dump operations.
module olar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [1:0]        op_i,
  input  olar_pkg::sts_t    sts_i,
  output logic              s_ready_o,
  output olar_pkg::cmd_t    cmd_o
);

  olar_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = s_valid_i && (state_q == olar_pkg::S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olar_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      olar_pkg::S_IDLE: begin
        if (accept) begin
          case (olar_pkg::op_e'(op_i))
            olar_pkg::OP_APPEND: state_d = olar_pkg::S_APPEND;
            olar_pkg::OP_REMOVE: state_d = olar_pkg::S_SEARCH;
            olar_pkg::OP_DUMP:   state_d = olar_pkg::S_DUMP;
            default:             state_d = olar_pkg::S_IDLE;
          endcase
        end
      end
      olar_pkg::S_APPEND: begin
        if (sts_i.out_free) state_d = olar_pkg::S_IDLE;
      end
      olar_pkg::S_SEARCH: begin
        if (!sts_i.idx_lt_cnt) begin
          if (sts_i.out_free) state_d = olar_pkg::S_IDLE;
        end else if (sts_i.match) begin
          state_d = olar_pkg::S_SHIFT;
        end
      end
      olar_pkg::S_SHIFT: begin
        if (!sts_i.idx_lt_cnt && sts_i.out_free) state_d = olar_pkg::S_IDLE;
      end
      olar_pkg::S_DUMP: begin
        if (sts_i.out_free && (sts_i.empty || sts_i.idx_last)) begin
          state_d = olar_pkg::S_IDLE;
        end
      end
      default: state_d = olar_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    s_ready_o     = (state_q == olar_pkg::S_IDLE);
    cmd_o         = '0;
    cmd_o.wr_sel  = olar_pkg::WR_TAIL;
    cmd_o.status  = olar_pkg::ST_APPENDED;
    cmd_o.val_sel = olar_pkg::VAL_ITEM;
    case (state_q)
      olar_pkg::S_IDLE: begin
        // Capture the request and prefetch the head entry.
        if (accept) begin
          cmd_o.load  = 1'b1;
          cmd_o.rd_en = 1'b1;
        end
      end
      olar_pkg::S_APPEND: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (sts_i.full) begin
            cmd_o.status = olar_pkg::ST_FULL;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      olar_pkg::S_SEARCH: begin
        if (!sts_i.idx_lt_cnt) begin
          if (sts_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.last   = 1'b1;
            cmd_o.status = olar_pkg::ST_NOT_FOUND;
          end
        end else begin
          // Step to the next entry; on a match this points at the first one to move.
          cmd_o.rd_en   = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      olar_pkg::S_SHIFT: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = olar_pkg::WR_SHIFT;
          cmd_o.rd_en   = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.last    = 1'b1;
          cmd_o.status  = olar_pkg::ST_REMOVED;
        end
      end
      olar_pkg::S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.empty) begin
            cmd_o.status  = olar_pkg::ST_EMPTY;
            cmd_o.val_sel = olar_pkg::VAL_ZERO;
            cmd_o.last    = 1'b1;
          end else begin
            cmd_o.status  = olar_pkg::ST_ELEMENT;
            cmd_o.val_sel = olar_pkg::VAL_RAM;
            cmd_o.last    = sts_i.idx_last;
            cmd_o.rd_en   = 1'b1;
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hdl/olar_dp.sv
// Datapath: list storage, count, walk index and the result register.
module olar_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olar_pkg::cmd_t                      cmd_i,
  input  logic [olar_pkg::VALUE_W-1:0]        item_value_i,
  input  logic                                m_ready_i,
  output olar_pkg::sts_t                      sts_o,
  output logic                                m_valid_o,
  output logic [olar_pkg::STATUS_W-1:0]       m_status_o,
  output logic [olar_pkg::VALUE_W-1:0]        m_value_o,
  output logic [olar_pkg::COUNT_W-1:0]        m_count_o,
  output logic                                m_last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (CW > olar_pkg::COUNT_W) ? CW : olar_pkg::COUNT_W;

  logic [olar_pkg::VALUE_W-1:0] val_q;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                idx_p1, idx_m1;
  logic [PW-1:0]                cnt_wide;

  logic [AW-1:0]                rd_addr, wr_addr;
  logic [olar_pkg::VALUE_W-1:0] rd_data, wr_data;

  logic                          m_valid_q;
  logic [olar_pkg::STATUS_W-1:0] m_status_q;
  logic [olar_pkg::VALUE_W-1:0]  m_value_q, m_value_d;
  logic [olar_pkg::COUNT_W-1:0]  m_count_q;
  logic                          m_last_q;

  assign idx_p1 = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);

  // List storage.
  assign rd_addr = cmd_i.load ? '0 : idx_p1[AW-1:0];
  assign wr_addr = (cmd_i.wr_sel == olar_pkg::WR_TAIL) ? cnt_q[AW-1:0] : idx_m1[AW-1:0];
  assign wr_data = (cmd_i.wr_sel == olar_pkg::WR_TAIL) ? val_q : rd_data;

  olar_ram #(
    .WIDTH (olar_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Entry count and walk index.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Request value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= item_value_i;
    end
  end

  // Status toward the controller.
  assign sts_o.full       = (cnt_q == CW'(DEPTH));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.idx_lt_cnt = (idx_q < cnt_q);
  assign sts_o.idx_last   = (idx_p1 == cnt_q);
  assign sts_o.match      = (rd_data == val_q);
  assign sts_o.out_free   = !m_valid_q || m_ready_i;

  // Result register.
  assign cnt_wide = PW'(cnt_d);

  always_comb begin
    case (cmd_i.val_sel)
      olar_pkg::VAL_RAM:  m_value_d = rd_data;
      olar_pkg::VAL_ZERO: m_value_d = '0;
      default:            m_value_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_status_q <= cmd_i.status;
      m_value_q  <= m_value_d;
      m_count_q  <= cnt_wide[olar_pkg::COUNT_W-1:0];
      m_last_q   <= cmd_i.last;
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_value_o  = m_value_q;
  assign m_count_o  = m_count_q;
  assign m_last_o   = m_last_q;

endmodule

FILE: hdl/ordered_list_append_remove_core.sv
// Append: the request is captured and its result is registered once the result register is
// free; the next request is taken back in idle. Remove: the entries are compared in turn; on a
// match each entry behind it moves one place toward the head, else the result is not found.
// Dump: one result per cycle from the list memory's read port while the result register is
// free; an empty list gives one empty result. The list memory has a single read and write port.
// Reset: asynchronous, active low; the list is empty and no result is pending afterward.
module ordered_list_append_remove_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] operation, [33:2] item_value, [39:34] zero
  input  logic [olar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [34:3] entry_value, [39:35] entry_count
  output logic [olar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);

  olar_pkg::cmd_t                cmd;
  olar_pkg::sts_t                sts;
  logic [olar_pkg::STATUS_W-1:0] m_status;
  logic [olar_pkg::VALUE_W-1:0]  m_value;
  logic [olar_pkg::COUNT_W-1:0]  m_count;

  // Controller.
  olar_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tdata[olar_pkg::OP_W-1:0]),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  // Datapath.
  olar_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_value_i (s_axis_tdata[olar_pkg::OP_W +: olar_pkg::VALUE_W]),
    .m_ready_i    (m_axis_tready),
    .sts_o        (sts),
    .m_valid_o    (m_axis_tvalid),
    .m_status_o   (m_status),
    .m_value_o    (m_value),
    .m_count_o    (m_count),
    .m_last_o     (m_axis_tlast)
  );

  // Pack the result fields.
  assign m_axis_tdata = {m_count, m_value, m_status};

endmodule

FILE: hdl/olar_checker.sv
// Port-level checks of the ordered list block.
module olar_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [olar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  logic [olar_pkg::STATUS_W-1:0] status;
  logic [olar_pkg::VALUE_W-1:0]  value;
  logic [olar_pkg::COUNT_W-1:0]  count;

  assign status = m_axis_tdata[2:0];
  assign value  = m_axis_tdata[34:3];
  assign count  = m_axis_tdata[39:35];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only dump elements may leave the run open.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != olar_pkg::ST_ELEMENT) |-> m_axis_tlast)
    else $error("single result without last marker");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 31) || (32'(count) <= DEPTH))
    else $error("entry count above capacity");

  // An empty dump reports zero value and zero count.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == olar_pkg::ST_EMPTY) |-> (value == '0) && (count == '0))
    else $error("empty dump with nonzero fields");

  // A full report only occurs when the list holds the capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == olar_pkg::ST_FULL) |->
      (DEPTH > 31) || (32'(count) == DEPTH))
    else $error("full report below capacity");

endmodule

bind ordered_list_append_remove_core olar_checker #(
  .DEPTH (DEPTH)
) u_olar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LIST_DEPTH = 16;
  localparam logic [olar_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_RANDOM = 300;
  localparam int HOLD_AT = 100;
  localparam int PAUSE_AT = 200;
  localparam int QUIET_AT = 250;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

  // One result as it leaves the block.
  typedef struct packed {
    olar_pkg::status_e                status;
    logic [olar_pkg::VALUE_W-1:0]     value;
    logic [olar_pkg::COUNT_W-1:0]     count;
    logic                             last;
  } result_t;

  // One row of directed stimulus; reps repeats the request with value + k.
  typedef struct packed {
    logic [olar_pkg::OP_W-1:0]    op;
    logic [olar_pkg::VALUE_W-1:0] value;
    int                           reps;
    logic                         typed;
    result_t                      exp;
  } dir_row_t;

  localparam result_t NO_EXP = '{olar_pkg::ST_APPENDED, 32'd0, 5'd0, 1'b0};
  localparam int NUM_DIR = 17;

  localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
    '{olar_pkg::OP_DUMP,   32'd0,         1,  1'b1,
      '{olar_pkg::ST_EMPTY,     32'd0,         5'd0,  1'b1}},
    '{olar_pkg::OP_REMOVE, 32'd5,         1,  1'b1,
      '{olar_pkg::ST_NOT_FOUND, 32'd5,         5'd0,  1'b1}},
    '{OP_UNUSED,           32'hFFFF_FFFF, 1,  1'b0, NO_EXP},
    '{olar_pkg::OP_APPEND, 32'h8000_0000, 1,  1'b1,
      '{olar_pkg::ST_APPENDED,  32'h8000_0000, 5'd1,  1'b1}},
    '{olar_pkg::OP_APPEND, 32'h7FFF_FFFF, 1,  1'b1,
      '{olar_pkg::ST_APPENDED,  32'h7FFF_FFFF, 5'd2,  1'b1}},
    '{olar_pkg::OP_APPEND, 32'hFFFF_FFFF, 1,  1'b1,
      '{olar_pkg::ST_APPENDED,  32'hFFFF_FFFF, 5'd3,  1'b1}},
    '{olar_pkg::OP_APPEND, 32'h0000_0000, 1,  1'b1,
      '{olar_pkg::ST_APPENDED,  32'h0000_0000, 5'd4,  1'b1}},
    '{olar_pkg::OP_APPEND, 32'h7FFF_FFFF, 1,  1'b1,
      '{olar_pkg::ST_APPENDED,  32'h7FFF_FFFF, 5'd5,  1'b1}},
    '{olar_pkg::OP_DUMP,   32'h1234_5678, 1,  1'b0, NO_EXP},
    '{olar_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1,  1'b1,
      '{olar_pkg::ST_REMOVED,   32'h7FFF_FFFF, 5'd4,  1'b1}},
    '{olar_pkg::OP_REMOVE, 32'd12345,     1,  1'b1,
      '{olar_pkg::ST_NOT_FOUND, 32'd12345,     5'd4,  1'b1}},
    '{olar_pkg::OP_APPEND, 32'h0000_1000, 12, 1'b0, NO_EXP},
    '{olar_pkg::OP_APPEND, 32'h5555_5555, 1,  1'b1,
      '{olar_pkg::ST_FULL,      32'h5555_5555, 5'd16, 1'b1}},
    '{olar_pkg::OP_DUMP,   32'hFFFF_FFFF, 1,  1'b0, NO_EXP},
    '{olar_pkg::OP_REMOVE, 32'h8000_0000, 1,  1'b1,
      '{olar_pkg::ST_REMOVED,   32'h8000_0000, 5'd15, 1'b1}},
    '{olar_pkg::OP_REMOVE, 32'h0000_100B, 1,  1'b1,
      '{olar_pkg::ST_REMOVED,   32'h0000_100B, 5'd14, 1'b1}},
    '{olar_pkg::OP_DUMP,   32'd0,         1,  1'b0, NO_EXP}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [olar_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [olar_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // Predictor state: the list as it should stand, and results still due.
  logic [olar_pkg::VALUE_W-1:0] list_model_q [$];
  result_t                      pending_results_q [$];

  bit no_idle = 1'b0;
  bit rx_hold_req = 1'b0;
  bit fill_phase = 1'b1;
  int errors = 0;
  int n_requests = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_hits = 0;
  int n_misses = 0;
  int n_dumps = 0;
  int peak_fill = 0;
  result_t seen_result;
  result_t due_result;

  ordered_list_append_remove_core #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Apply one accepted request to the list model and queue its results.
  task automatic predict_list_op(input logic [olar_pkg::OP_W-1:0] op,
                                 input logic [olar_pkg::VALUE_W-1:0] val);
    result_t r;
    int hit;
    n_requests++;
    r.value = val;
    r.last = 1'b1;
    case (op)
      olar_pkg::OP_APPEND: begin
        if (list_model_q.size() >= LIST_DEPTH) begin
          r.status = olar_pkg::ST_FULL;
          n_full++;
        end else begin
          list_model_q.push_back(val);
          r.status = olar_pkg::ST_APPENDED;
        end
        r.count = olar_pkg::COUNT_W'(list_model_q.size());
        pending_results_q.push_back(r);
      end
      olar_pkg::OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < list_model_q.size(); i++) begin
          if (hit < 0 && list_model_q[i] == val) hit = i;
        end
        if (hit < 0) begin
          r.status = olar_pkg::ST_NOT_FOUND;
          n_misses++;
        end else begin
          list_model_q.delete(hit);
          r.status = olar_pkg::ST_REMOVED;
          n_hits++;
        end
        r.count = olar_pkg::COUNT_W'(list_model_q.size());
        pending_results_q.push_back(r);
      end
      olar_pkg::OP_DUMP: begin
        n_dumps++;
        if (list_model_q.size() == 0) begin
          r.status = olar_pkg::ST_EMPTY;
          r.value = '0;
          r.count = '0;
          pending_results_q.push_back(r);
        end else begin
          // One element result per entry, head first, last flag on the tail.
          for (int i = 0; i < list_model_q.size(); i++) begin
            r.status = olar_pkg::ST_ELEMENT;
            r.value = list_model_q[i];
            r.count = olar_pkg::COUNT_W'(list_model_q.size());
            r.last = (i == list_model_q.size() - 1);
            pending_results_q.push_back(r);
          end
        end
      end
      default: begin
        // The unused operation code leaves the list alone and yields nothing.
        n_ignored++;
      end
    endcase
    if (list_model_q.size() > peak_fill) peak_fill = list_model_q.size();
  endtask

  // Offer one request, with an occasional short gap ahead of it.
  task automatic send_request(input logic [olar_pkg::OP_W-1:0] op,
                              input logic [olar_pkg::VALUE_W-1:0] val);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(olar_pkg::IN_TDATA_W - olar_pkg::OP_W - olar_pkg::VALUE_W){1'b0}},
                     val, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_list_op(op, val);
  endtask

  // Values: a small pool so duplicates arise, the extremes, or anything.
  function automatic logic [olar_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return olar_pkg::VALUE_W'($urandom_range(0, 7)) - olar_pkg::VALUE_W'(3);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Alternate between filling the list to full and draining it to empty.
  task automatic pick_request(output logic [olar_pkg::OP_W-1:0] op,
                              output logic [olar_pkg::VALUE_W-1:0] val);
    int roll;
    int append_pct;
    int remove_pct;
    if (fill_phase && list_model_q.size() == LIST_DEPTH && $urandom_range(0, 3) == 0)
      fill_phase = 1'b0;
    else if (!fill_phase && list_model_q.size() == 0)
      fill_phase = 1'b1;
    append_pct = fill_phase ? 65 : 20;
    remove_pct = fill_phase ? 20 : 60;
    roll = $urandom_range(0, 99);
    val = pick_value();
    if (roll < append_pct) begin
      op = olar_pkg::OP_APPEND;
    end else if (roll < append_pct + remove_pct) begin
      op = olar_pkg::OP_REMOVE;
      // Mostly remove something that is there, so the shift path is exercised.
      if (list_model_q.size() != 0 && $urandom_range(0, 3) != 0)
        val = list_model_q[$urandom_range(0, list_model_q.size() - 1)];
    end else if (roll < 97) begin
      op = olar_pkg::OP_DUMP;
    end else begin
      op = OP_UNUSED;
    end
  endtask

  // Result side: random short stalls, and one long hold-off on request.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare every accepted result with the oldest one still due.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.status = olar_pkg::status_e'(m_axis_tdata[olar_pkg::STATUS_W-1:0]);
      seen_result.value = m_axis_tdata[olar_pkg::STATUS_W +: olar_pkg::VALUE_W];
      seen_result.count =
        m_axis_tdata[olar_pkg::STATUS_W + olar_pkg::VALUE_W +: olar_pkg::COUNT_W];
      seen_result.last = m_axis_tlast;
      if (pending_results_q.size() == 0) begin
        $error("unexpected result: status %0d value %h count %0d last %0d",
               seen_result.status, seen_result.value, seen_result.count, seen_result.last);
        errors++;
      end else begin
        due_result = pending_results_q.pop_front();
        n_checked++;
        if (seen_result.status !== due_result.status) begin
          $error("status: expected %0d, got %0d", due_result.status, seen_result.status);
          errors++;
        end
        if (seen_result.value !== due_result.value) begin
          $error("entry_value: expected %h, got %h", due_result.value, seen_result.value);
          errors++;
        end
        if (seen_result.count !== due_result.count) begin
          $error("entry_count: expected %0d, got %0d", due_result.count, seen_result.count);
          errors++;
        end
        if (seen_result.last !== due_result.last) begin
          $error("last: expected %0d, got %0d", due_result.last, seen_result.last);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random requests, drain.
  initial begin
    logic [olar_pkg::OP_W-1:0]    rnd_op;
    logic [olar_pkg::VALUE_W-1:0] rnd_val;
    int                           issued;
    issued = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part; typed rows replace the predicted single result.
    for (int r = 0; r < NUM_DIR; r++) begin
      for (int k = 0; k < DIR_TABLE[r].reps; k++) begin
        send_request(DIR_TABLE[r].op, DIR_TABLE[r].value + olar_pkg::VALUE_W'(k));
        if (DIR_TABLE[r].typed) begin
          void'(pending_results_q.pop_back());
          pending_results_q.push_back(DIR_TABLE[r].exp);
        end
      end
    end

    // Random part, with the long result stall and one full drain inside it.
    while (issued < NUM_RANDOM) begin
      pick_request(rnd_op, rnd_val);
      send_request(rnd_op, rnd_val);
      if (rnd_op != OP_UNUSED) begin
        issued++;
        if (issued == HOLD_AT) rx_hold_req = 1'b1;
        if (issued == QUIET_AT) no_idle = 1'b1;
        if (issued == PAUSE_AT) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_results_q.size() != 0) @(posedge clk_i);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d with the unused code), %0d results checked.",
             n_requests, n_ignored, n_checked);
    $display("%0d appends refused when full, %0d removes found, %0d missed, %0d dumps, peak %0d.",
             n_full, n_hits, n_misses, n_dumps, peak_fill);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", pending_results_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
